// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every check samples on the rising clock and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define CCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication check.
`define CCI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/cci_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cci_pkg: shared types and constants of the calorimeter cell index block
// Fixed-point formats, CORDIC angle steps and the per-layer bin tables.
// ---------------------------------------------------------------------------
package cci_pkg;

  // Angle format: radians, signed, AngleFracBits fraction bits
  localparam int unsigned AngleFracBits = 16;
  localparam int unsigned CordicIter    = AngleFracBits + 2;
  localparam int unsigned IterW         = $clog2(CordicIter);
  localparam int unsigned CordicGuard   = 24;
  localparam int unsigned CordicW       = 44;
  localparam int unsigned AccW          = 35;
  localparam int unsigned AngW          = AngleFracBits + 3;
  localparam int unsigned OffW          = AngleFracBits;
  localparam int unsigned RecipShift    = 32;
  localparam int unsigned RecipW        = 33;
  localparam int unsigned BinW          = 8;
  localparam int unsigned CellW         = 10;
  localparam int unsigned LayerW        = 2;
  localparam int unsigned ZW            = 16;
  localparam int unsigned PosW          = 17;

  localparam logic [CellW-1:0] OutBase = 10'd960;

  localparam logic signed [AccW-1:0] RoundBias = AccW'(64'd1 << (31 - AngleFracBits));
  localparam int unsigned AngShift = 32 - AngleFracBits;

  // Bin widths: round(width * 2^F), widths in micro radians
  localparam longint unsigned Scale = 64'd1 << AngleFracBits;
  localparam longint unsigned WxL0 = (64'd100000 * Scale + 64'd500000) / 64'd1000000;
  localparam longint unsigned WxL1 = (64'd98000 * Scale + 64'd500000) / 64'd1000000;
  localparam longint unsigned WxL2 = (64'd24500 * Scale + 64'd500000) / 64'd1000000;
  localparam longint unsigned WyL0 = (64'd25000 * Scale + 64'd500000) / 64'd1000000;
  localparam longint unsigned WyL1 = (64'd3125 * Scale + 64'd500000) / 64'd1000000;
  localparam longint unsigned WyL3 = (64'd50000 * Scale + 64'd500000) / 64'd1000000;

  localparam longint unsigned RecipOne = 64'd1 << RecipShift;
  localparam longint unsigned RxL0 = RecipOne / WxL0;
  localparam longint unsigned RxL1 = RecipOne / WxL1;
  localparam longint unsigned RxL2 = RecipOne / WxL2;
  localparam longint unsigned RyL0 = RecipOne / WyL0;
  localparam longint unsigned RyL1 = RecipOne / WyL1;
  localparam longint unsigned RyL3 = RecipOne / WyL3;

  // Configuration register indexes
  typedef enum logic [1:0] {
    RegLayer1Z = 2'd0,
    RegLayer2Z = 2'd1,
    RegLayer3Z = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [AccW-1:0]    ang;
  } lane_t;

  typedef struct packed {
    logic [LayerW-1:0] layer;
    logic              neg_x;
    logic              neg_y;
    logic              z_zero;
  } side_t;

  typedef struct packed {
    lane_t lx;
    lane_t ly;
    side_t side;
  } cell_bus_t;

  // round(atan(2^-i) * 2^32)
  function automatic logic signed [AccW-1:0] step_angle(input logic [IterW-1:0] idx);
    logic signed [AccW-1:0] r;
    r = '0;
    unique case (idx)
      5'd0:  r = AccW'(64'd3373259426);
      5'd1:  r = AccW'(64'd1991351318);
      5'd2:  r = AccW'(64'd1052175346);
      5'd3:  r = AccW'(64'd534100635);
      5'd4:  r = AccW'(64'd268086748);
      5'd5:  r = AccW'(64'd134174063);
      5'd6:  r = AccW'(64'd67103403);
      5'd7:  r = AccW'(64'd33553749);
      5'd8:  r = AccW'(64'd16777131);
      5'd9:  r = AccW'(64'd8388597);
      5'd10: r = AccW'(64'd4194303);
      5'd11: r = AccW'(64'd2097152);
      5'd12: r = AccW'(64'd1048576);
      5'd13: r = AccW'(64'd524288);
      5'd14: r = AccW'(64'd262144);
      5'd15: r = AccW'(64'd131072);
      5'd16: r = AccW'(64'd65536);
      5'd17: r = AccW'(64'd32768);
      5'd18: r = AccW'(64'd16384);
      5'd19: r = AccW'(64'd8192);
      5'd20: r = AccW'(64'd4096);
      5'd21: r = AccW'(64'd2048);
      5'd22: r = AccW'(64'd1024);
      5'd23: r = AccW'(64'd512);
      5'd24: r = AccW'(64'd256);
      5'd25: r = AccW'(64'd128);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [OffW-1:0] width_x(input logic [LayerW-1:0] layer);
    logic [OffW-1:0] r;
    r = '0;
    unique case (layer)
      2'd0:    r = OffW'(WxL0);
      2'd1:    r = OffW'(WxL1);
      default: r = OffW'(WxL2);
    endcase
    return r;
  endfunction

  function automatic logic [OffW-1:0] width_y(input logic [LayerW-1:0] layer);
    logic [OffW-1:0] r;
    r = '0;
    unique case (layer)
      2'd1:    r = OffW'(WyL1);
      2'd3:    r = OffW'(WyL3);
      default: r = OffW'(WyL0);
    endcase
    return r;
  endfunction

  function automatic logic [RecipW-1:0] recip_x(input logic [LayerW-1:0] layer);
    logic [RecipW-1:0] r;
    r = '0;
    unique case (layer)
      2'd0:    r = RecipW'(RxL0);
      2'd1:    r = RecipW'(RxL1);
      default: r = RecipW'(RxL2);
    endcase
    return r;
  endfunction

  function automatic logic [RecipW-1:0] recip_y(input logic [LayerW-1:0] layer);
    logic [RecipW-1:0] r;
    r = '0;
    unique case (layer)
      2'd1:    r = RecipW'(RyL1);
      2'd3:    r = RecipW'(RyL3);
      default: r = RecipW'(RyL0);
    endcase
    return r;
  endfunction

  // Bin counts as log2: x 4,4,16,16 and y 16,128,16,8
  function automatic logic [2:0] nx_log2(input logic [LayerW-1:0] layer);
    logic [2:0] r;
    r = '0;
    unique case (layer) inside
      2'd0, 2'd1: r = 3'd2;
      default:    r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] ny_log2(input logic [LayerW-1:0] layer);
    logic [2:0] r;
    r = '0;
    unique case (layer)
      2'd1:    r = 3'd7;
      2'd3:    r = 3'd3;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [CellW-1:0] cell_offset(input logic [LayerW-1:0] layer);
    logic [CellW-1:0] r;
    r = '0;
    unique case (layer)
      2'd0:    r = 10'd0;
      2'd1:    r = 10'd64;
      2'd2:    r = 10'd576;
      default: r = 10'd832;
    endcase
    return r;
  endfunction

endpackage

// ===== src/cci_cordic_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cci_cordic_cell: one vectoring CORDIC iteration for both angle lanes
// Rotates x/y lanes by the step of its iteration and passes the side data on.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cci_cordic_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [cci_pkg::IterW-1:0]   iter_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  cci_pkg::cell_bus_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output cci_pkg::cell_bus_t          out_data_o
);

  logic               valid_q;
  cci_pkg::cell_bus_t data_q, data_d;
  logic signed [cci_pkg::AccW-1:0] step;

  assign step = cci_pkg::step_angle(iter_i);

  // Advance one iteration on each lane
  always_comb begin
    data_d = in_data_i;
    if (!in_data_i.lx.y[cci_pkg::CordicW-1]) begin
      data_d.lx.x   = in_data_i.lx.x + (in_data_i.lx.y >>> iter_i);
      data_d.lx.y   = in_data_i.lx.y - (in_data_i.lx.x >>> iter_i);
      data_d.lx.ang = in_data_i.lx.ang + step;
    end else begin
      data_d.lx.x   = in_data_i.lx.x - (in_data_i.lx.y >>> iter_i);
      data_d.lx.y   = in_data_i.lx.y + (in_data_i.lx.x >>> iter_i);
      data_d.lx.ang = in_data_i.lx.ang - step;
    end
    if (!in_data_i.ly.y[cci_pkg::CordicW-1]) begin
      data_d.ly.x   = in_data_i.ly.x + (in_data_i.ly.y >>> iter_i);
      data_d.ly.y   = in_data_i.ly.y - (in_data_i.ly.x >>> iter_i);
      data_d.ly.ang = in_data_i.ly.ang + step;
    end else begin
      data_d.ly.x   = in_data_i.ly.x - (in_data_i.ly.y >>> iter_i);
      data_d.ly.y   = in_data_i.ly.y + (in_data_i.ly.x >>> iter_i);
      data_d.ly.ang = in_data_i.ly.ang - step;
    end
  end

  // Take a new transaction when empty or when the next cell takes ours
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // x never goes negative in vectoring mode
  `CCI_ASSERT_IMPL(a_x_nonneg, valid_q, !data_q.lx.x[cci_pkg::CordicW-1] && !data_q.ly.x[cci_pkg::CordicW-1], "cordic x went negative")
  // a stalled cell keeps its contents
  `CCI_ASSERT(a_stall_hold, valid_q && !out_ready_i |=> valid_q && $stable(data_q), "stalled cell lost data")

endmodule

// ===== src/cci_bin_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cci_bin_unit: angle rounding, binning and cell number
// Four stages: offset and range check, reciprocal product, remainder fix,
// cell number. The last stage is the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cci_bin_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  cci_pkg::cell_bus_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cci_pkg::CellW-1:0]        cell_index_o,
  output logic [cci_pkg::LayerW-1:0]       layer_o,
  output logic                             out_of_range_o
);

  localparam int unsigned OW = cci_pkg::AngW + 1;
  localparam int unsigned PW = cci_pkg::OffW + cci_pkg::RecipW;
  localparam int unsigned QW = cci_pkg::BinW + cci_pkg::OffW;

  logic va_q, vb_q, vc_q, vd_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  logic [cci_pkg::LayerW-1:0] la_q, lb_q, lc_q, ld_q;
  logic oa_q, ob_q, oc_q, od_q;
  logic [cci_pkg::OffW-1:0] oxa_q, oya_q, oxb_q, oyb_q;
  logic [cci_pkg::BinW-1:0] qxb_q, qyb_q, xbc_q, ybc_q;
  logic [cci_pkg::CellW-1:0] cell_q;

  // Ready ripples back from the output register
  assign rdy_d      = !vd_q || out_ready_i;
  assign rdy_c      = !vc_q || rdy_d;
  assign rdy_b      = !vb_q || rdy_c;
  assign rdy_a      = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  // Stage A: round the angles, apply the sign and shift by half the range
  logic signed [cci_pkg::AccW-1:0] rnd_x, rnd_y;
  logic signed [cci_pkg::AngW-1:0] ang_x, ang_y, sgn_x, sgn_y;
  logic signed [OW-1:0] off_x, off_y;
  logic                 bad_x, bad_y;
  logic [cci_pkg::LayerW-1:0] lay;
  logic [cci_pkg::OffW-1:0] wx, wy;

  always_comb begin
    lay   = in_data_i.side.layer;
    wx    = cci_pkg::width_x(lay);
    wy    = cci_pkg::width_y(lay);
    rnd_x = in_data_i.lx.ang + cci_pkg::RoundBias;
    rnd_y = in_data_i.ly.ang + cci_pkg::RoundBias;
    ang_x = cci_pkg::AngW'(rnd_x >>> cci_pkg::AngShift);
    ang_y = cci_pkg::AngW'(rnd_y >>> cci_pkg::AngShift);
    sgn_x = in_data_i.side.neg_x ? -ang_x : ang_x;
    sgn_y = in_data_i.side.neg_y ? -ang_y : ang_y;
    off_x = OW'(sgn_x) + $signed(OW'((wx << cci_pkg::nx_log2(lay)) >> 1));
    off_y = OW'(sgn_y) + $signed(OW'((wy << cci_pkg::ny_log2(lay)) >> 1));
    bad_x = off_x[OW-1] || (off_x == '0)
            || (off_x >= $signed(OW'(wx << cci_pkg::nx_log2(lay))));
    bad_y = off_y[OW-1] || (off_y == '0)
            || (off_y >= $signed(OW'(wy << cci_pkg::ny_log2(lay))));
  end

  // Stage B: quotient estimate by reciprocal multiply
  logic [PW-1:0] px, py;
  always_comb begin
    px = PW'(oxa_q) * PW'(cci_pkg::recip_x(la_q));
    py = PW'(oya_q) * PW'(cci_pkg::recip_y(la_q));
  end

  // Stage C: the estimate is low by at most one, fix it with the remainder
  logic [QW-1:0] mx, my;
  logic [cci_pkg::OffW-1:0] rx, ry;
  logic [cci_pkg::BinW-1:0] bx, by;
  always_comb begin
    mx = QW'(qxb_q) * QW'(cci_pkg::width_x(lb_q));
    my = QW'(qyb_q) * QW'(cci_pkg::width_y(lb_q));
    rx = oxb_q - mx[cci_pkg::OffW-1:0];
    ry = oyb_q - my[cci_pkg::OffW-1:0];
    bx = (rx >= cci_pkg::width_x(lb_q)) ? qxb_q + 1'b1 : qxb_q;
    by = (ry >= cci_pkg::width_y(lb_q)) ? qyb_q + 1'b1 : qyb_q;
  end

  // Stage D: flat cell number
  logic [cci_pkg::CellW-1:0] cell_d;
  always_comb begin
    if (oc_q) begin
      cell_d = cci_pkg::OutBase + cci_pkg::CellW'(lc_q);
    end else begin
      cell_d = cci_pkg::cell_offset(lc_q)
             + (cci_pkg::CellW'(xbc_q) << cci_pkg::ny_log2(lc_q))
             + cci_pkg::CellW'(ybc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      la_q  <= lay;
      oa_q  <= in_data_i.side.z_zero || bad_x || bad_y;
      oxa_q <= off_x[cci_pkg::OffW-1:0];
      oya_q <= off_y[cci_pkg::OffW-1:0];
    end
    if (rdy_b && va_q) begin
      lb_q  <= la_q;
      ob_q  <= oa_q;
      oxb_q <= oxa_q;
      oyb_q <= oya_q;
      qxb_q <= px[cci_pkg::RecipShift +: cci_pkg::BinW];
      qyb_q <= py[cci_pkg::RecipShift +: cci_pkg::BinW];
    end
    if (rdy_c && vb_q) begin
      lc_q  <= lb_q;
      oc_q  <= ob_q;
      xbc_q <= bx;
      ybc_q <= by;
    end
    if (rdy_d && vc_q) begin
      ld_q   <= lc_q;
      od_q   <= oc_q;
      cell_q <= cell_d;
    end
  end

  assign out_valid_o    = vd_q;
  assign cell_index_o   = cell_q;
  assign layer_o        = ld_q;
  assign out_of_range_o = od_q;

  // an in-range hit stays inside the cell map and within its layer's bins
  `CCI_ASSERT_IMPL(a_in_map, vd_q && !od_q, cell_q < cci_pkg::OutBase, "cell index beyond map")
  `CCI_ASSERT_IMPL(a_y_bin, vc_q && !oc_q, (cci_pkg::CellW'(ybc_q) >> cci_pkg::ny_log2(lc_q)) == '0, "y bin beyond layer count")

endmodule

// ===== src/calorimeter_cell_index.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// calorimeter_cell_index: hit position to flat calorimeter cell number
// Layer from z thresholds, angles by a CORDIC cell chain, binning per layer.
// ---------------------------------------------------------------------------
//   channel   handshake                  payload
//   input     in_valid_i / in_ready_o    pos_x_i, pos_y_i, pos_z_i
//   output    out_valid_o / out_ready_i  cell_index_o, layer_o, out_of_range_o
//   config    cfg_we_i                   cfg_addr_i, cfg_wdata_i
//
// One transaction per cycle while the output is not stalled; the pipeline is the
// input register, one CORDIC cell per iteration and four binning stages.
// Every stage has its own valid bit and a stalled output fills the stages
// behind it one at a time. Reset empties the pipeline and loads the
// default z thresholds; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module calorimeter_cell_index (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [cci_pkg::PosW-1:0]    pos_x_i,
  input  logic signed [cci_pkg::PosW-1:0]    pos_y_i,
  input  logic [cci_pkg::ZW-1:0]             pos_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [cci_pkg::CellW-1:0]          cell_index_o,
  output logic [cci_pkg::LayerW-1:0]         layer_o,
  output logic                               out_of_range_o,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_addr_i,
  input  logic [cci_pkg::ZW-1:0]             cfg_wdata_i
);

  localparam int unsigned NCell = cci_pkg::CordicIter;
  localparam int unsigned AbsW  = cci_pkg::PosW + 1;

  // Threshold registers
  logic [cci_pkg::ZW-1:0] z1_q, z2_q, z3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z1_q <= 16'd24000;
      z2_q <= 16'd25451;
      z3_q <= 16'd30850;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        cci_pkg::RegLayer1Z: z1_q <= cfg_wdata_i;
        cci_pkg::RegLayer2Z: z2_q <= cfg_wdata_i;
        cci_pkg::RegLayer3Z: z3_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input stage: layer pick and CORDIC start vectors
  logic [cci_pkg::LayerW-1:0] lay;
  logic [AbsW-1:0]            abs_x, abs_y;
  cci_pkg::cell_bus_t         in_d, in_q;
  logic                       in_v_q;

  always_comb begin
    if (pos_z_i < z1_q)      lay = 2'd0;
    else if (pos_z_i < z2_q) lay = 2'd1;
    else if (pos_z_i < z3_q) lay = 2'd2;
    else                     lay = 2'd3;
    abs_x = pos_x_i[cci_pkg::PosW-1] ? AbsW'(-AbsW'(pos_x_i)) : AbsW'(pos_x_i);
    abs_y = pos_y_i[cci_pkg::PosW-1] ? AbsW'(-AbsW'(pos_y_i)) : AbsW'(pos_y_i);
    in_d.lx.x        = cci_pkg::CordicW'(pos_z_i) << cci_pkg::CordicGuard;
    in_d.lx.y        = cci_pkg::CordicW'(abs_x) << cci_pkg::CordicGuard;
    in_d.lx.ang      = '0;
    in_d.ly.x        = cci_pkg::CordicW'(pos_z_i) << cci_pkg::CordicGuard;
    in_d.ly.y        = cci_pkg::CordicW'(abs_y) << cci_pkg::CordicGuard;
    in_d.ly.ang      = '0;
    in_d.side.layer  = lay;
    in_d.side.neg_x  = pos_x_i[cci_pkg::PosW-1];
    in_d.side.neg_y  = pos_y_i[cci_pkg::PosW-1];
    in_d.side.z_zero = (pos_z_i == '0);
  end

  logic               vld [NCell+1];
  logic               rdy [NCell+1];
  cci_pkg::cell_bus_t bus [NCell+1];

  assign in_ready_o = !in_v_q || rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_d;
    end
  end

  assign vld[0] = in_v_q;
  assign bus[0] = in_q;

  // CORDIC chain, one iteration per cell
  for (genvar g = 0; g < NCell; g++) begin : g_cell
    cci_cordic_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .iter_i      (cci_pkg::IterW'(g)),
      .in_valid_i  (vld[g]),
      .in_ready_o  (rdy[g]),
      .in_data_i   (bus[g]),
      .out_valid_o (vld[g+1]),
      .out_ready_i (rdy[g+1]),
      .out_data_o  (bus[g+1])
    );
  end

  cci_bin_unit u_bin (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (vld[NCell]),
    .in_ready_o     (rdy[NCell]),
    .in_data_i      (bus[NCell]),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cell_index_o   (cell_index_o),
    .layer_o        (layer_o),
    .out_of_range_o (out_of_range_o)
  );

  // out-of-range results carry the escape code of their layer
  `CCI_ASSERT_IMPL(a_oor_code, out_valid_o && out_of_range_o, cell_index_o == (cci_pkg::OutBase + cci_pkg::CellW'(layer_o)), "bad out-of-range code")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for calorimeter_cell_index
// Hit positions stream through a valid/ready driver with random gaps. An
// in-bench CORDIC and binning model predicts each cell number, layer and
// range flag. The monitor compares every output transaction in order. The
// z thresholds are rewritten between phases, extremes and unordered values
// included.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned AngF = cci_pkg::AngleFracBits;
  localparam int unsigned Steps = AngF + 2;
  localparam int unsigned WatchLimit = 3000;
  localparam int unsigned DrainCycles = 40;
  localparam logic [1:0] RegUnused = 2'd3;
  localparam logic [9:0] OutOfRangeBase = 10'd960;

  localparam int unsigned BinsX[4] = '{4, 4, 16, 16};
  localparam int unsigned BinsY[4] = '{16, 128, 16, 8};
  localparam longint unsigned WidthXMicro[4] = '{100000, 98000, 24500, 24500};
  localparam longint unsigned WidthYMicro[4] = '{25000, 3125, 25000, 50000};
  localparam int unsigned LayerBase[4] = '{0, 64, 576, 832};

  typedef struct {
    logic signed [cci_pkg::PosW-1:0] x;
    logic signed [cci_pkg::PosW-1:0] y;
    logic [cci_pkg::ZW-1:0]          z;
  } hit_t;

  typedef struct {
    logic [cci_pkg::CellW-1:0]  idx;
    logic [cci_pkg::LayerW-1:0] layer;
    logic                       oor;
  } cell_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic signed [cci_pkg::PosW-1:0] pos_x_i, pos_y_i;
  logic [cci_pkg::ZW-1:0] pos_z_i;
  logic out_valid_o, out_ready_i;
  logic [cci_pkg::CellW-1:0] cell_index_o;
  logic [cci_pkg::LayerW-1:0] layer_o;
  logic out_of_range_o;
  logic cfg_we_i;
  logic [1:0] cfg_addr_i;
  logic [cci_pkg::ZW-1:0] cfg_wdata_i;

  calorimeter_cell_index dut (.*);

  hit_t    hit_q[$];
  cell_t   cell_q[$];
  longint  atan_q32[Steps];
  logic [cci_pkg::ZW-1:0] z_start[3];
  int unsigned mismatches = 0;
  int unsigned hits_taken = 0;
  bit calm = 0;
  int unsigned idle_cycles = 0;

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Build the CORDIC step table, atan(2^-i) in Q32, from its power series
  function automatic void build_atan_steps();
    longint sum;
    longint unsigned term;
    atan_q32[0] = 64'sd3373259426;
    for (int i = 1; i < Steps; i++) begin
      sum = 0;
      for (int n = 1; i * n <= 62; n += 2) begin
        term = (64'd1 << (62 - i * n)) / n;
        if (((n >> 1) & 1) != 0) sum -= longint'(term);
        else sum += longint'(term);
      end
      atan_q32[i] = (sum + (64'sd1 <<< 29)) >>> 30;
    end
  endfunction

  // Signed atan(v/z) in Q16 by vectoring CORDIC on |v|
  function automatic longint hit_angle(longint v, longint z);
    longint x, y, acc, nx, r;
    x = z <<< 24;
    y = (v < 0 ? -v : v) <<< 24;
    acc = 0;
    for (int i = 0; i < Steps; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        acc += atan_q32[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        acc -= atan_q32[i];
      end
      x = nx;
    end
    r = (acc + (64'sd1 <<< (31 - AngF))) >>> (32 - AngF);
    return v < 0 ? -r : r;
  endfunction

  // Bin number of an angle, or -1 outside the strict outer bounds
  function automatic int angle_bin(longint ang, int unsigned n, longint unsigned wmicro);
    longint w, o;
    w = longint'(((wmicro << AngF) + 64'd500000) / 64'd1000000);
    o = ang + longint'(n / 2) * w;
    if (o <= 0 || o >= longint'(n) * w) return -1;
    return int'(o / w);
  endfunction

  function automatic cell_t predict_cell(hit_t h);
    cell_t r;
    int xb, yb;
    int unsigned lay;
    if (h.z < z_start[0]) lay = 0;
    else if (h.z < z_start[1]) lay = 1;
    else if (h.z < z_start[2]) lay = 2;
    else lay = 3;
    xb = -1;
    yb = -1;
    if (h.z != 0) begin
      xb = angle_bin(hit_angle(longint'(h.x), longint'(h.z)), BinsX[lay], WidthXMicro[lay]);
      yb = angle_bin(hit_angle(longint'(h.y), longint'(h.z)), BinsY[lay], WidthYMicro[lay]);
    end
    r.layer = lay[1:0];
    if (xb < 0 || yb < 0) begin
      r.idx = OutOfRangeBase + 10'(lay);
      r.oor = 1'b1;
    end else begin
      r.idx = 10'(LayerBase[lay] + xb * BinsY[lay] + yb);
      r.oor = 1'b0;
    end
    return r;
  endfunction

  // Driver: predict on acceptance, then offer the next hit or idle a while
  int unsigned tx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    hit_t h;
    logic take;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      pos_x_i <= '0;
      pos_y_i <= '0;
      pos_z_i <= '0;
      tx_gap = 0;
    end else begin
      take = !in_valid_i;
      if (in_valid_i && in_ready_o) begin
        h.x = pos_x_i;
        h.y = pos_y_i;
        h.z = pos_z_i;
        cell_q.push_back(predict_cell(h));
        hits_taken++;
        take = 1'b1;
      end
      if (take) begin
        if (tx_gap == 0 && !calm && $urandom_range(0, 9) == 0)
          tx_gap = $urandom_range(1, 13);
        if (tx_gap > 0 || hit_q.size() == 0) begin
          if (tx_gap > 0) tx_gap--;
          in_valid_i <= 1'b0;
        end else begin
          h = hit_q.pop_front();
          in_valid_i <= 1'b1;
          pos_x_i <= h.x;
          pos_y_i <= h.y;
          pos_z_i <= h.z;
        end
      end
    end
  end

  // Monitor: check each result, stall in bursts, hold off once for long
  int unsigned rx_gap = 0;
  bit long_hold_done = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    cell_t exp_c;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (cell_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result cell=%0d", cell_index_o);
        end else begin
          exp_c = cell_q.pop_front();
          if (cell_index_o !== exp_c.idx || layer_o !== exp_c.layer ||
              out_of_range_o !== exp_c.oor) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp cell=%0d layer=%0d oor=%0d got cell=%0d layer=%0d oor=%0d",
                       exp_c.idx, exp_c.layer, exp_c.oor,
                       cell_index_o, layer_o, out_of_range_o);
          end
        end
      end
      if (!long_hold_done && hits_taken >= 120) begin
        long_hold_done = 1;
        rx_gap = 200;
      end else if (rx_gap == 0 && !calm && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(1, 13);
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: stop when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] addr, logic [cci_pkg::ZW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= val;
    if (addr != RegUnused) z_start[addr] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_thresholds(logic [cci_pkg::ZW-1:0] a, logic [cci_pkg::ZW-1:0] b,
                                logic [cci_pkg::ZW-1:0] c);
    write_reg(cci_pkg::RegLayer1Z, a);
    write_reg(cci_pkg::RegLayer2Z, b);
    write_reg(cci_pkg::RegLayer3Z, c);
  endtask

  // Hold until every queued hit went in and every result came out
  task automatic drain();
    while (hit_q.size() != 0 || in_valid_i || cell_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [cci_pkg::PosW-1:0] pick_pos(logic [cci_pkg::ZW-1:0] z);
    int span;
    if ($urandom_range(0, 4) == 0) return cci_pkg::PosW'($urandom);
    span = int'(z) / 2 + 1;
    return cci_pkg::PosW'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [cci_pkg::ZW-1:0] pick_z();
    int t;
    case ($urandom_range(0, 3))
      0: return cci_pkg::ZW'($urandom_range(1, 65535));
      default: begin
        t = int'(z_start[$urandom_range(0, 2)]) + int'($urandom_range(0, 8)) - 4;
        if ($urandom_range(0, 1) == 0) t = int'($urandom_range(15000, 40000));
        if (t < 1) t = 1;
        if (t > 65535) t = 65535;
        return cci_pkg::ZW'(t);
      end
    endcase
  endfunction

  task automatic push_hit(logic signed [cci_pkg::PosW-1:0] x,
                          logic signed [cci_pkg::PosW-1:0] y,
                          logic [cci_pkg::ZW-1:0] z);
    hit_t h;
    h.x = x;
    h.y = y;
    h.z = z;
    hit_q.push_back(h);
  endtask

  task automatic push_random(int count);
    logic [cci_pkg::ZW-1:0] z;
    for (int i = 0; i < count; i++) begin
      z = pick_z();
      push_hit(pick_pos(z), pick_pos(z), z);
    end
  endtask

  initial begin
    build_atan_steps();
    z_start[0] = 16'd24000;
    z_start[1] = 16'd25451;
    z_start[2] = 16'd30850;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, zero z, thresholds, on-axis and symmetric hits
    push_hit(17'sd0, 17'sd0, 16'd1);
    push_hit(17'sd0, 17'sd0, 16'd0);
    push_hit(-17'sd65536, 17'sd65535, 16'd0);
    push_hit(-17'sd65536, -17'sd65536, 16'd1);
    push_hit(17'sd65535, 17'sd65535, 16'd65535);
    push_hit(-17'sd65536, -17'sd65536, 16'd65535);
    push_hit(17'sd100, 17'sd100, 16'd23999);
    push_hit(17'sd100, -17'sd100, 16'd24000);
    push_hit(17'sd500, 17'sd20, 16'd25450);
    push_hit(-17'sd500, -17'sd20, 16'd25451);
    push_hit(17'sd3000, 17'sd1000, 16'd30849);
    push_hit(-17'sd3000, -17'sd1000, 16'd30850);
    push_hit(17'sd4800, 17'sd4800, 16'd24000);
    push_hit(-17'sd4800, -17'sd4800, 16'd24000);
    push_hit(17'sd4900, 17'sd0, 16'd24000);
    push_hit(17'sd0, 17'sd9000, 16'd40000);
    push_hit(17'sd0, -17'sd9000, 16'd40000);
    push_hit(17'sd65535, 17'sd0, 16'd65535);
    push_hit(17'sd1, -17'sd1, 16'd1);
    push_hit(-17'sd1, 17'sd1, 16'd65535);
    push_random(90);
    drain();

    // Lowest thresholds plus a write to the unused index
    set_thresholds(16'd1, 16'd1, 16'd1);
    write_reg(RegUnused, 16'hFFFF);
    push_hit(17'sd5, 17'sd5, 16'd0);
    push_random(80);
    drain();

    // Highest thresholds
    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_hit(17'sd5, 17'sd5, 16'd65535);
    push_random(80);
    drain();

    // Unordered thresholds
    set_thresholds(16'd40000, 16'd10000, 16'd20000);
    push_random(90);
    drain();

    // Random ordered thresholds
    set_thresholds(16'(20000 + $urandom_range(0, 4000)), 16'(25000 + $urandom_range(0, 4000)),
                   16'(30000 + $urandom_range(0, 4000)));
    push_random(90);
    drain();

    // Defaults again, last stretch with no idling
    set_thresholds(16'd24000, 16'd25451, 16'd30850);
    calm = 1;
    push_random(100);
    drain();

    if (mismatches == 0 && cell_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
